@@ rtl/csd_pkg.sv @@
// ---------------------------------------------------------------------------
// Corner stability detector package
// Shared widths, window sizes, register indexes and the cell status type.
// ---------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

    // Window geometry.
    localparam int WINDOW_DEPTH = 10;
    localparam int MIN_FILL     = 3;

    // Field widths.
    localparam int COORD_W = 12;
    localparam int CONF_W  = 8;
    localparam int RUN_W   = 8;
    localparam int SQ_W    = 2 * COORD_W;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register reset values.
    localparam logic [COORD_W-1:0] MAX_DIST_RST  = 12'd20;
    localparam logic [SQ_W-1:0]    LIMIT_RST     = 24'd400;
    localparam logic [CONF_W-1:0]  MIN_CONF_RST  = 8'd179;
    localparam logic [RUN_W-1:0]   CAP_FRAMES_RST = 8'd3;
    localparam logic               AUTO_CAP_RST  = 1'b1;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_MAX_DIST   = 2'd0,
        REG_MIN_CONF   = 2'd1,
        REG_CAP_FRAMES = 2'd2,
        REG_AUTO_CAP   = 2'd3
    } t_reg_idx;

    // Contents of one window cell: a frame is held, and its pair check passed.
    typedef struct packed {
        logic valid;
        logic ok;
    } t_cell;

endpackage

`default_nettype wire

@@ rtl/csd_cell.sv @@
// ---------------------------------------------------------------------------
// Corner stability detector window cell
// Holds one frame's pair flag and passes it to the older neighbour on shift.
// ---------------------------------------------------------------------------
`default_nettype none

module csd_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire csd_pkg::t_cell i_prev,
    input  wire logic          i_next_valid,
    output csd_pkg::t_cell     o_cell,
    output logic               o_term
);
    import csd_pkg::*;

    t_cell r_cell;

    // The cell takes its newer neighbour's contents on every frame entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (i_shift) begin
            r_cell <= i_prev;
        end
    end

    // The oldest frame in the window has no older neighbour, and its flag
    // is not examined; every other held frame must have passed its check.
    assign o_term = r_cell.ok || !i_next_valid;
    assign o_cell = r_cell;

endmodule

`default_nettype wire

@@ rtl/csd_dist.sv @@
// ---------------------------------------------------------------------------
// Corner stability detector pair check
// Two-stage pipeline: absolute differences, then squares and the limit compare.
// ---------------------------------------------------------------------------
`default_nettype none

module csd_dist (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [csd_pkg::COORD_W-1:0]  i_x,
    input  wire logic [csd_pkg::COORD_W-1:0]  i_y,
    input  wire logic [csd_pkg::CONF_W-1:0]   i_conf,
    input  wire logic [csd_pkg::CONF_W-1:0]   i_min_conf,
    input  wire logic [csd_pkg::SQ_W-1:0]     i_limit,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_ok
);
    import csd_pkg::*;

    logic               r_has_prev;
    logic [COORD_W-1:0] r_last_x;
    logic [COORD_W-1:0] r_last_y;

    logic               r_v1;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_dy;
    logic               r_cok1;

    logic               r_v2;
    logic [SQ_W-1:0]    r_dx2;
    logic [SQ_W-1:0]    r_dy2;
    logic               r_cok2;

    logic               w_en1;
    logic               w_en2;
    logic               w_acc;
    logic [COORD_W-1:0] n_dx;
    logic [COORD_W-1:0] n_dy;
    logic [SQ_W:0]      w_sum;

    // Each stage moves when its successor is empty or moving on.
    assign w_en2   = !r_v2 || !i_stall;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign w_acc   = i_valid && w_en1;

    // Distance to the previous frame, per axis.
    assign n_dx = (i_x > r_last_x) ? (i_x - r_last_x) : (r_last_x - i_x);
    assign n_dy = (i_y > r_last_y) ? (i_y - r_last_y) : (r_last_y - i_y);

    // Control state of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_prev <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (w_acc) begin
                r_has_prev <= 1'b1;
            end
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // First stage: differences and the confidence check.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_last_x <= i_x;
            r_last_y <= i_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_cok1   <= r_has_prev && (i_conf >= i_min_conf);
        end
    end

    // Second stage: squared differences.
    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_dx2  <= r_dx * r_dx;
            r_dy2  <= r_dy * r_dy;
            r_cok2 <= r_cok1;
        end
    end

    // Squared distance against the squared limit.
    assign w_sum   = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign o_ok    = r_cok2 && (w_sum <= {1'b0, i_limit});
    assign o_valid = r_v2;

endmodule

`default_nettype wire

@@ rtl/corner_stability_detector.sv @@
// ---------------------------------------------------------------------------
// Corner stability detector
// Checks each frame's corner movement against its predecessor and its confidence
// against a minimum, keeps the pair flags of the last frames in a row of cells,
// and counts the run of stable frames with an optional capture trigger.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Word
//  input     in         i_in_valid / o_in_stall     corner x, corner y, confidence
//  output    out        o_out_valid / i_out_stall   stable, stable run, capture
//  config    in         APB, pready always high     four registers at 4*index
//
//  One word is taken per cycle while the input is not stalled; its result
//  passes the difference, square, window and output registers in turn, the
//  first of them loaded at the edge that accepts it.
//  The squaring multipliers have a register stage of their own.
//  Reset is synchronous and active low; it empties the window and the stages.
//  A stalled output only holds the input back once every stage is full.
// ---------------------------------------------------------------------------
`default_nettype none

module corner_stability_detector (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Input words.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [csd_pkg::COORD_W-1:0]  i_corner_x,
    input  wire logic [csd_pkg::COORD_W-1:0]  i_corner_y,
    input  wire logic [csd_pkg::CONF_W-1:0]   i_confidence,
    // Result words.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_stable,
    output logic [csd_pkg::RUN_W-1:0]         o_stable_run,
    output logic                              o_capture,
    // Configuration port.
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [csd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [csd_pkg::DATA_W-1:0]   pwdata,
    output logic [csd_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import csd_pkg::*;

    // Configuration registers; the squared limit is kept alongside.
    logic [COORD_W-1:0] r_max_dist;
    logic [SQ_W-1:0]    r_limit;
    logic [CONF_W-1:0]  r_min_conf;
    logic [RUN_W-1:0]   r_cap_frames;
    logic               r_auto_cap;

    logic               w_wr;
    t_reg_idx           w_idx;
    logic [COORD_W-1:0] w_wdist;

    // Pair check pipeline.
    logic               w_dist_valid;
    logic               w_dist_stall;
    logic               w_dist_ok;

    // Window stage and output register.
    logic               r_v3;
    logic               w_en3;
    logic               w_en_out;
    logic               w_shift;
    logic [RUN_W-1:0]   r_run;
    logic [RUN_W-1:0]   n_run;
    logic               w_stable;
    logic               w_capture;
    logic               r_out_valid;
    logic               r_out_stable;
    logic [RUN_W-1:0]   r_out_run;
    logic               r_out_capture;

    // Window cells.
    t_cell              w_cell [WINDOW_DEPTH];
    t_cell              w_prev [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] w_next_valid;
    logic [WINDOW_DEPTH-1:0] w_term;

    // Register write decode.
    assign w_wr    = psel && penable && pwrite;
    assign w_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wdist = pwdata[COORD_W-1:0];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist   <= MAX_DIST_RST;
            r_limit      <= LIMIT_RST;
            r_min_conf   <= MIN_CONF_RST;
            r_cap_frames <= CAP_FRAMES_RST;
            r_auto_cap   <= AUTO_CAP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_DIST: begin
                    r_max_dist <= w_wdist;
                    r_limit    <= w_wdist * w_wdist;
                end
                REG_MIN_CONF:   r_min_conf   <= pwdata[CONF_W-1:0];
                REG_CAP_FRAMES: r_cap_frames <= pwdata[RUN_W-1:0];
                REG_AUTO_CAP:   r_auto_cap   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_MAX_DIST:   prdata[COORD_W-1:0] = r_max_dist;
            REG_MIN_CONF:   prdata[CONF_W-1:0]  = r_min_conf;
            REG_CAP_FRAMES: prdata[RUN_W-1:0]   = r_cap_frames;
            REG_AUTO_CAP:   prdata[0]           = r_auto_cap;
            default:        prdata              = '0;
        endcase
    end

    // Distance and confidence check against the previous frame.
    csd_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_x        (i_corner_x),
        .i_y        (i_corner_y),
        .i_conf     (i_confidence),
        .i_min_conf (r_min_conf),
        .i_limit    (r_limit),
        .o_valid    (w_dist_valid),
        .i_stall    (w_dist_stall),
        .o_ok       (w_dist_ok)
    );

    // Stage enables downstream of the pair check.
    assign w_en_out     = !r_out_valid || !i_out_stall;
    assign w_en3        = !r_v3 || w_en_out;
    assign w_dist_stall = !w_en3;
    assign w_shift      = w_dist_valid && w_en3;

    // Row of window cells, newest at index zero.
    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_prev[k] = '{valid: 1'b1, ok: w_dist_ok};
        end else begin : g_body
            assign w_prev[k] = w_cell[k-1];
        end
        if (k == WINDOW_DEPTH - 1) begin : g_tail
            assign w_next_valid[k] = 1'b0;
        end else begin : g_inner
            assign w_next_valid[k] = w_cell[k+1].valid;
        end

        csd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_shift),
            .i_prev       (w_prev[k]),
            .i_next_valid (w_next_valid[k]),
            .o_cell       (w_cell[k]),
            .o_term       (w_term[k])
        );
    end

    // The window is stable once enough frames are held and every flag but the oldest frame's passes.
    if (MIN_FILL <= WINDOW_DEPTH) begin : g_fill
        assign w_stable = w_cell[MIN_FILL-1].valid && (&w_term);
    end else begin : g_nofill
        assign w_stable = 1'b0;
    end

    // Run counter update and the capture trigger.
    always_comb begin
        if (!w_stable) begin
            n_run = '0;
        end else if (r_run == RUN_MAX) begin
            n_run = r_run;
        end else begin
            n_run = r_run + 1'b1;
        end
        w_capture = r_auto_cap && w_stable && (n_run >= r_cap_frames);
    end

    // Control state of the window stage and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_run       <= '0;
        end else begin
            if (w_en3) begin
                r_v3 <= w_dist_valid;
            end
            if (w_en_out) begin
                r_out_valid <= r_v3;
            end
            if (w_en_out && r_v3) begin
                r_run <= w_capture ? '0 : n_run;
            end
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (w_en_out && r_v3) begin
            r_out_stable  <= w_stable;
            r_out_run     <= n_run;
            r_out_capture <= w_capture;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_stable     = r_out_stable;
    assign o_stable_run = r_out_run;
    assign o_capture    = r_out_capture;

endmodule

`default_nettype wire
